// File: rtl/tusc_pkg.sv
// ----------------------------------------------------------------------------
// tusc_pkg
// Shared widths, register indexes and defaults for the texture upload size
// check block
// ----------------------------------------------------------------------------
package tusc_pkg;

  localparam int EXTENT_BITS_DEF = 16;

  localparam int LEVEL_W        = 5;
  localparam int SLICE_W        = 16;
  localparam int ROW_STRIDE_W   = 32;
  localparam int IMAGE_STRIDE_W = 48;
  localparam int SAMPLES_W      = 7;
  localparam int BYTES_W        = 64;

  localparam int MIP_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int BLOCK_W  = 5;
  localparam int CFG_IDX_W = 3;

  localparam int WORD_W = 32;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP_NARROW = 8;
  localparam int DIV_STEP_WIDE   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH   = 3'd0,
    REG_TEX_HEIGHT  = 3'd1,
    REG_TEX_DEPTH   = 3'd2,
    REG_MIP_COUNT   = 3'd3,
    REG_ARRAY_COUNT = 3'd4,
    REG_BLOCK_W     = 3'd5,
    REG_BLOCK_H     = 3'd6,
    REG_BLOCK_BYTES = 3'd7
  } reg_idx_t;

endpackage

// File: rtl/tusc_req_if.sv
// ----------------------------------------------------------------------------
// tusc_req_if
// Request channel of the texture upload size check
// ----------------------------------------------------------------------------
interface tusc_req_if;
  logic                                valid;
  logic                                ready;
  logic [tusc_pkg::LEVEL_W-1:0]        level;
  logic [tusc_pkg::SLICE_W-1:0]        slice;
  logic [tusc_pkg::ROW_STRIDE_W-1:0]   row_stride;
  logic [tusc_pkg::IMAGE_STRIDE_W-1:0] image_stride;
  logic                                is_volume;
  logic [tusc_pkg::SAMPLES_W-1:0]      samples;
  logic                                format_usable;

  modport source (output valid, level, slice, row_stride, image_stride, is_volume,
                  samples, format_usable, input ready);
  modport sink (input valid, level, slice, row_stride, image_stride, is_volume,
                samples, format_usable, output ready);
endinterface

// File: rtl/tusc_res_if.sv
// ----------------------------------------------------------------------------
// tusc_res_if
// Result channel of the texture upload size check
// ----------------------------------------------------------------------------
interface tusc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [tusc_pkg::BYTES_W-1:0] required_bytes;

  modport source (output valid, accepted, required_bytes, input ready);
  modport sink (input valid, accepted, required_bytes, output ready);
endinterface

// File: rtl/tusc_div.sv
// ----------------------------------------------------------------------------
// tusc_div
// Pipelined restoring divider, a fixed number of quotient bits per stage,
// with a side payload carried alongside
// ----------------------------------------------------------------------------
module tusc_div #(
  parameter int NW     = 32,
  parameter int DW     = 5,
  parameter int SW     = 1,
  parameter int K      = 8,
  parameter int STAGES = 4
) (
  input  logic              clk,
  input  logic [STAGES-1:0] en,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [SW-1:0]     side,
  output logic [NW-1:0]     quo,
  output logic [DW-1:0]     rem,
  output logic [SW-1:0]     side_out
);

  localparam int NP = STAGES * K;

  logic [NP-1:0] num_q  [STAGES];
  logic [NP-1:0] quo_q  [STAGES];
  logic [DW-1:0] rem_q  [STAGES];
  logic [DW-1:0] den_q  [STAGES];
  logic [SW-1:0] side_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [NP-1:0] n_in, q_in, n_next, q_next;
    logic [DW-1:0] r_in, d_in, r_next;
    logic [SW-1:0] s_in;
    logic [DW:0]   t;

    if (g == 0) begin : g_first
      assign n_in = NP'(num);
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
      assign s_in = side;
    end else begin : g_rest
      assign n_in = num_q[g-1];
      assign q_in = quo_q[g-1];
      assign r_in = rem_q[g-1];
      assign d_in = den_q[g-1];
      assign s_in = side_q[g-1];
    end

    always_comb begin
      n_next = n_in;
      q_next = q_in;
      r_next = r_in;
      t      = '0;
      for (int k = 0; k < K; k++) begin
        t      = {r_next, n_next[NP-1]};
        n_next = {n_next[NP-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t      = t - {1'b0, d_in};
          q_next = {q_next[NP-2:0], 1'b1};
        end else begin
          q_next = {q_next[NP-2:0], 1'b0};
        end
        r_next = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        num_q[g]  <= n_next;
        quo_q[g]  <= q_next;
        rem_q[g]  <= r_next;
        den_q[g]  <= d_in;
        side_q[g] <= s_in;
      end
    end
  end

  assign quo      = quo_q[STAGES-1][NW-1:0];
  assign rem      = rem_q[STAGES-1];
  assign side_out = side_q[STAGES-1];

endmodule

// File: rtl/texture_upload_size_check_core.sv
// ----------------------------------------------------------------------------
// texture_upload_size_check_core
// Checks an upload request against the programmed texture and gives the
// number of source bytes it needs
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    level slice row_stride image_stride is_volume
//                               samples format_usable
//  res      out  valid/ready    accepted required_bytes
//  cfg      in   cfg_we         cfg_index cfg_data
//
//  one request per cycle unless res back-pressure stalls the pipeline; the
//  image pitch divider resolves 4 bits a stage
//  every stage holds its request while the next one is full and stalled
//  synchronous reset empties the pipeline and loads register defaults
// ----------------------------------------------------------------------------
module texture_upload_size_check_core #(
  parameter int EXTENT_BITS = tusc_pkg::EXTENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tusc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((EXTENT_BITS > tusc_pkg::COUNT_W) ? EXTENT_BITS
                 : tusc_pkg::COUNT_W)-1:0] cfg_data,
  tusc_req_if.sink                       req,
  tusc_res_if.source                     res
);

  localparam int E    = EXTENT_BITS;
  localparam int XW   = E + 1;
  localparam int NATW = XW + tusc_pkg::BLOCK_W;
  localparam int ERPW = (NATW > tusc_pkg::WORD_W) ? NATW : tusc_pkg::WORD_W + 1;
  localparam int HW   = ERPW - tusc_pkg::WORD_W;
  localparam int PKW  = (ERPW + XW > tusc_pkg::BYTES_W) ? ERPW + XW : tusc_pkg::BYTES_W + 1;
  localparam int RBW  = ERPW + tusc_pkg::BLOCK_W;
  localparam int ISW  = tusc_pkg::IMAGE_STRIDE_W;
  localparam int IBW  = ISW + tusc_pkg::BLOCK_W;
  localparam int QW   = tusc_pkg::WORD_W + E;
  localparam int RW   = tusc_pkg::BYTES_W + E + 1;
  localparam int BW   = tusc_pkg::BYTES_W;
  localparam int RSW  = tusc_pkg::ROW_STRIDE_W;

  localparam int STA = (XW + tusc_pkg::DIV_STEP_NARROW - 1) / tusc_pkg::DIV_STEP_NARROW;
  localparam int STB = (ERPW + tusc_pkg::DIV_STEP_NARROW - 1) / tusc_pkg::DIV_STEP_NARROW;
  localparam int STC = (ISW + tusc_pkg::DIV_STEP_WIDE - 1) / tusc_pkg::DIV_STEP_WIDE;

  localparam int IA  = 1;
  localparam int IN  = IA + STA;
  localparam int IB  = IN + 1;
  localparam int IM1 = IB + STB;
  localparam int IM2 = IM1 + 1;
  localparam int IC  = IM2 + 1;
  localparam int IF1 = IC + STC;
  localparam int IF2 = IF1 + 1;
  localparam int NS  = IF2 + 1;

  localparam int SAW = E + RSW + ISW;
  localparam int SBW = ERPW + XW + 1 + E + ISW;
  localparam int SCW = BW + BW + XW + 1 + E + 1;

  // configuration registers
  logic [E-1:0]                      tex_width, tex_height, tex_depth;
  logic [tusc_pkg::MIP_W-1:0]        mip_count;
  logic [tusc_pkg::COUNT_W-1:0]      array_count;
  logic [tusc_pkg::BLOCK_W-1:0]      block_width, block_height, bytes_per_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width       <= '0;
      tex_height      <= '0;
      tex_depth       <= '0;
      mip_count       <= '0;
      array_count     <= '0;
      block_width     <= tusc_pkg::BLOCK_W'(1);
      block_height    <= tusc_pkg::BLOCK_W'(1);
      bytes_per_block <= '0;
    end else if (cfg_we) begin
      unique case (tusc_pkg::reg_idx_t'(cfg_index))
        tusc_pkg::REG_TEX_WIDTH:   tex_width       <= cfg_data[E-1:0];
        tusc_pkg::REG_TEX_HEIGHT:  tex_height      <= cfg_data[E-1:0];
        tusc_pkg::REG_TEX_DEPTH:   tex_depth       <= cfg_data[E-1:0];
        tusc_pkg::REG_MIP_COUNT:   mip_count       <= cfg_data[tusc_pkg::MIP_W-1:0];
        tusc_pkg::REG_ARRAY_COUNT: array_count     <= cfg_data[tusc_pkg::COUNT_W-1:0];
        tusc_pkg::REG_BLOCK_W:     block_width     <= cfg_data[tusc_pkg::BLOCK_W-1:0];
        tusc_pkg::REG_BLOCK_H:     block_height    <= cfg_data[tusc_pkg::BLOCK_W-1:0];
        tusc_pkg::REG_BLOCK_BYTES: bytes_per_block <= cfg_data[tusc_pkg::BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [NS-1:0] vld, en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || res.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~en) | ({vld[NS-2:0], req.valid} & en);
    end
  end

  assign req.ready = en[0];

  // stage 0: mip extents and request checks
  logic [E-1:0]   w_sh, h_sh, d_sh, w_m, h_m, d_m;
  logic           bad0;
  logic           s0_bad;
  logic [XW-1:0]  s0_nx, s0_ny;
  logic [E-1:0]   s0_dm1;
  logic [RSW-1:0] s0_rs;
  logic [ISW-1:0] s0_is;

  always_comb begin
    w_sh = tex_width  >> req.level;
    h_sh = tex_height >> req.level;
    d_sh = tex_depth  >> req.level;
    w_m  = (w_sh == '0) ? E'(1) : w_sh;
    h_m  = (h_sh == '0) ? E'(1) : h_sh;
    d_m  = (d_sh == '0) ? E'(1) : d_sh;
    bad0 = (tex_width == '0) || (tex_height == '0) || (tex_depth == '0) ||
           (mip_count == '0) || (array_count == '0) ||
           (req.samples != tusc_pkg::SAMPLES_W'(1)) ||
           (req.level >= mip_count) || (req.slice >= array_count) ||
           !req.format_usable || (block_width == '0) || (block_height == '0) ||
           (bytes_per_block == '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_bad <= bad0;
      s0_nx  <= XW'(w_m) + XW'(block_width) - XW'(1);
      s0_ny  <= XW'(h_m) + XW'(block_height) - XW'(1);
      s0_dm1 <= req.is_volume ? (d_m - E'(1)) : '0;
      s0_rs  <= req.row_stride;
      s0_is  <= req.image_stride;
    end
  end

  // block counts across and down
  logic [XW-1:0]                a_bcx, a_bcy;
  logic [tusc_pkg::BLOCK_W-1:0] a_remx, a_remy;
  logic [SAW-1:0]               a_side;
  logic                         a_bad;

  tusc_div #(
    .NW(XW), .DW(tusc_pkg::BLOCK_W), .SW(SAW), .K(tusc_pkg::DIV_STEP_NARROW), .STAGES(STA)
  ) u_div_x (
    .clk(clk), .en(en[IA +: STA]), .num(s0_nx), .den(block_width),
    .side({s0_dm1, s0_rs, s0_is}), .quo(a_bcx), .rem(a_remx), .side_out(a_side)
  );

  tusc_div #(
    .NW(XW), .DW(tusc_pkg::BLOCK_W), .SW(1), .K(tusc_pkg::DIV_STEP_NARROW), .STAGES(STA)
  ) u_div_y (
    .clk(clk), .en(en[IA +: STA]), .num(s0_ny), .den(block_height),
    .side(s0_bad), .quo(a_bcy), .rem(a_remy), .side_out(a_bad)
  );

  // effective row pitch
  logic [NATW-1:0] nat;
  logic [ERPW-1:0] erp;
  logic [E-1:0]    a_dm1;
  logic [RSW-1:0]  a_rs;
  logic [ISW-1:0]  a_is;
  logic [ERPW-1:0] n_erp;
  logic [XW-1:0]   n_bcy;
  logic            n_bad;
  logic [E-1:0]    n_dm1;
  logic [ISW-1:0]  n_is;

  always_comb begin
    {a_dm1, a_rs, a_is} = a_side;
    nat = NATW'(a_bcx) * NATW'(bytes_per_block);
    erp = (a_rs != '0) ? ERPW'(a_rs) : ERPW'(nat);
  end

  always_ff @(posedge clk) begin
    if (en[IN]) begin
      n_erp <= erp;
      n_bcy <= a_bcy;
      n_bad <= a_bad || (erp == '0) || (erp < ERPW'(nat)) || (a_remx != a_remy && 1'b0);
      n_dm1 <= a_dm1;
      n_is  <= a_is;
    end
  end

  // row pitch in blocks
  logic [ERPW-1:0]              b_rowb;
  logic [tusc_pkg::BLOCK_W-1:0] b_rem;
  logic [SBW-1:0]               b_side;
  logic [ERPW-1:0]              b_erp;
  logic [XW-1:0]                b_bcy;
  logic                         b_bad;
  logic [E-1:0]                 b_dm1;
  logic [ISW-1:0]               b_is;

  tusc_div #(
    .NW(ERPW), .DW(tusc_pkg::BLOCK_W), .SW(SBW), .K(tusc_pkg::DIV_STEP_NARROW), .STAGES(STB)
  ) u_div_row (
    .clk(clk), .en(en[IB +: STB]), .num(n_erp), .den(bytes_per_block),
    .side({n_erp, n_bcy, n_bad, n_dm1, n_is}), .quo(b_rowb), .rem(b_rem), .side_out(b_side)
  );

  // packed image size partial products
  logic [RBW-1:0]            rb_prod;
  logic [tusc_pkg::WORD_W+XW-1:0] m1_plo;
  logic [HW+XW-1:0]          m1_phi;
  logic [ERPW-1:0]           m1_erp;
  logic [XW-1:0]             m1_bcy;
  logic                      m1_bad;
  logic [E-1:0]              m1_dm1;
  logic [ISW-1:0]            m1_is;

  always_comb begin
    {b_erp, b_bcy, b_bad, b_dm1, b_is} = b_side;
    rb_prod = RBW'(b_rowb) * RBW'(block_width);
  end

  always_ff @(posedge clk) begin
    if (en[IM1]) begin
      m1_plo <= (tusc_pkg::WORD_W + XW)'(b_erp[tusc_pkg::WORD_W-1:0]) *
                (tusc_pkg::WORD_W + XW)'(b_bcy);
      m1_phi <= (HW + XW)'(b_erp[ERPW-1:tusc_pkg::WORD_W]) * (HW + XW)'(b_bcy);
      m1_bad <= b_bad || (b_rem != '0) || (|rb_prod[RBW-1:tusc_pkg::WORD_W]);
      m1_erp <= b_erp;
      m1_bcy <= b_bcy;
      m1_dm1 <= b_dm1;
      m1_is  <= b_is;
    end
  end

  // packed image size and effective image pitch
  logic [PKW-1:0] pfull;
  logic [BW-1:0]  pk, edp;
  logic           iz;
  logic [BW-1:0]  m2_edp, m2_pk;
  logic [XW-1:0]  m2_bcy;
  logic           m2_bad, m2_iz;
  logic [E-1:0]   m2_dm1;
  logic [ISW-1:0] m2_is;
  logic [ERPW-1:0] m2_erp;

  always_comb begin
    pfull = PKW'(m1_plo) + (PKW'(m1_phi) << tusc_pkg::WORD_W);
    pk    = pfull[BW-1:0];
    iz    = (m1_is == '0);
    edp   = iz ? pk : BW'(m1_is);
  end

  always_ff @(posedge clk) begin
    if (en[IM2]) begin
      m2_edp <= edp;
      m2_pk  <= pk;
      m2_bcy <= m1_bcy;
      m2_bad <= m1_bad || (|pfull[PKW-1:BW]) || (edp == '0) || (edp < pk);
      m2_iz  <= iz;
      m2_dm1 <= m1_dm1;
      m2_is  <= m1_is;
      m2_erp <= m1_erp;
    end
  end

  // image pitch in rows
  logic [ISW-1:0]  c_quo;
  logic [ERPW-1:0] c_rem;
  logic [SCW-1:0]  c_side;
  logic [BW-1:0]   c_edp, c_pk;
  logic [XW-1:0]   c_bcy;
  logic            c_bad, c_iz;
  logic [E-1:0]    c_dm1;

  tusc_div #(
    .NW(ISW), .DW(ERPW), .SW(SCW), .K(tusc_pkg::DIV_STEP_WIDE), .STAGES(STC)
  ) u_div_img (
    .clk(clk), .en(en[IC +: STC]), .num(m2_is), .den(m2_erp),
    .side({m2_edp, m2_pk, m2_bcy, m2_bad, m2_dm1, m2_iz}),
    .quo(c_quo), .rem(c_rem), .side_out(c_side)
  );

  logic [ISW-1:0] imgb;
  logic [IBW-1:0] ib_prod;
  logic [QW-1:0]  f1_qlo, f1_qhi;
  logic [BW-1:0]  f1_pk;
  logic           f1_bad;

  always_comb begin
    {c_edp, c_pk, c_bcy, c_bad, c_dm1, c_iz} = c_side;
    imgb    = c_iz ? ISW'(c_bcy) : c_quo;
    ib_prod = IBW'(imgb) * IBW'(block_height);
  end

  always_ff @(posedge clk) begin
    if (en[IF1]) begin
      f1_qlo <= QW'(c_edp[tusc_pkg::WORD_W-1:0]) * QW'(c_dm1);
      f1_qhi <= QW'(c_edp[BW-1:tusc_pkg::WORD_W]) * QW'(c_dm1);
      f1_pk  <= c_pk;
      f1_bad <= c_bad || (!c_iz && (c_rem != '0)) ||
                (|ib_prod[IBW-1:tusc_pkg::WORD_W]);
    end
  end

  // total size over all depth slices
  logic [RW-1:0] rfull;
  logic          out_acc;
  logic [BW-1:0] out_bytes;

  always_comb begin
    rfull = RW'(f1_qlo) + (RW'(f1_qhi) << tusc_pkg::WORD_W) + RW'(f1_pk);
  end

  always_ff @(posedge clk) begin
    if (en[IF2]) begin
      if (f1_bad || (|rfull[RW-1:BW])) begin
        out_acc   <= 1'b0;
        out_bytes <= '0;
      end else begin
        out_acc   <= 1'b1;
        out_bytes <= rfull[BW-1:0];
      end
    end
  end

  assign res.valid          = vld[NS-1];
  assign res.accepted       = out_acc;
  assign res.required_bytes = out_bytes;

endmodule
